// ----- rtl/core/rc4_stream_cipher_top_macros.svh -----
// Assertion macros shared by the RC4 stream cipher RTL.
// Files that check their own logic include this header; it depends on nothing else.
// Both macros expect signals named clk and rst in the including module.
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH
`ifndef SYNTH
// Checked property with the check suspended while reset is high.
`define RC4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that is also evaluated during reset.
`define RC4_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RC4_ASSERT(lbl, prop, msg)
`define RC4_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/rc4_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RC4 stream cipher.
// Used by every module of the block except rc4_ram; depends on nothing.
package rc4_pkg;

  // Permutation table geometry.
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // Key storage.
  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_W         = MAX_KEY_BYTES * 8;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int KLEN_W        = 6;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Register indexes (byte address is eight times the index).
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;

  // Reset value of the key length register.
  localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = 6'd4;

  // Input and output beats.
  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_beat_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [KLEN_W-1:0] key_length;
    logic [KEY_W-1:0]  key;
  } cfg_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KRD_N,
    ST_KRD_J,
    ST_KWR_N,
    ST_KWR_J,
    ST_PRE,
    ST_RD_J,
    ST_RD_T,
    ST_WR_J,
    ST_HOLD
  } ctrl_state_t;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    DOP_IDLE,
    DOP_FILL,
    DOP_KRD_N,
    DOP_KRD_J,
    DOP_KWR_N,
    DOP_KWR_J,
    DOP_RD_J,
    DOP_RD_T,
    DOP_WR_J,
    DOP_HOLD
  } dp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    dp_op_t op;
    logic   take_item;
    logic   start_byte;
    logic   load_out;
    logic   finish_ks;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_last;
    logic out_free;
    logic item_last;
  } status_t;

endpackage

// ----- rtl/core/rc4_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents. No dependencies.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rc4_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers: key length and four 64-bit key words.
// Depends on rc4_pkg for register indexes and the configuration struct.
module rc4_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rc4_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rc4_pkg::cfg_t                   cfg
);

  logic [rc4_pkg::KLEN_W-1:0]     key_length;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_word_0;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_word_1;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_word_2;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_word_3;
  logic [rc4_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rc4_pkg::CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes in the access phase; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= rc4_pkg::KEY_LENGTH_RST;
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rc4_pkg::REG_KEY_LENGTH: key_length <= pwdata[rc4_pkg::KLEN_W-1:0];
        rc4_pkg::REG_KEY_WORD_0: key_word_0 <= pwdata;
        rc4_pkg::REG_KEY_WORD_1: key_word_1 <= pwdata;
        rc4_pkg::REG_KEY_WORD_2: key_word_2 <= pwdata;
        rc4_pkg::REG_KEY_WORD_3: key_word_3 <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      rc4_pkg::REG_KEY_LENGTH:
        prdata = {{(rc4_pkg::CFG_DATA_W-rc4_pkg::KLEN_W){1'b0}}, key_length};
      rc4_pkg::REG_KEY_WORD_0: prdata = key_word_0;
      rc4_pkg::REG_KEY_WORD_1: prdata = key_word_1;
      rc4_pkg::REG_KEY_WORD_2: prdata = key_word_2;
      rc4_pkg::REG_KEY_WORD_3: prdata = key_word_3;
      default:                 prdata = '0;
    endcase
  end

  assign cfg.key_length = key_length;
  assign cfg.key        = {key_word_3, key_word_2, key_word_1, key_word_0};

endmodule

// ----- rtl/core/rc4_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the key schedule and the per-byte permutation update.
// Depends on rc4_pkg for states and command/status structs, and on the macro header.
`include "rc4_stream_cipher_top_macros.svh"
module rc4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rc4_pkg::status_t  status,
  output rc4_pkg::cmd_t     cmd
);

  rc4_pkg::ctrl_state_t state;
  rc4_pkg::ctrl_state_t state_next;
  logic                 need_rekey;
  logic                 need_rekey_next;
  logic                 accept;

  // Input beats are taken when idle, or while the previous byte finishes if it
  // can hand off its result and does not end a message.
  assign in_stall = !((state == rc4_pkg::ST_IDLE) ||
                      ((state == rc4_pkg::ST_WR_J) && status.out_free && !status.item_last));
  assign accept   = in_valid && !in_stall;

  // State and rekey flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rc4_pkg::ST_IDLE;
      need_rekey <= 1'b1;
    end else begin
      state      <= state_next;
      need_rekey <= need_rekey_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    need_rekey_next = need_rekey;
    cmd.op          = rc4_pkg::DOP_IDLE;
    cmd.take_item   = 1'b0;
    cmd.start_byte  = 1'b0;
    cmd.load_out    = 1'b0;
    cmd.finish_ks   = 1'b0;
    case (state)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.take_item = 1'b1;
          if (need_rekey) begin
            state_next = rc4_pkg::ST_FILL;
          end else begin
            cmd.start_byte = 1'b1;
            state_next     = rc4_pkg::ST_RD_J;
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        cmd.op = rc4_pkg::DOP_FILL;
        if (status.n_last) begin
          state_next = rc4_pkg::ST_KRD_N;
        end
      end
      rc4_pkg::ST_KRD_N: begin
        cmd.op     = rc4_pkg::DOP_KRD_N;
        state_next = rc4_pkg::ST_KRD_J;
      end
      rc4_pkg::ST_KRD_J: begin
        cmd.op     = rc4_pkg::DOP_KRD_J;
        state_next = rc4_pkg::ST_KWR_N;
      end
      rc4_pkg::ST_KWR_N: begin
        cmd.op     = rc4_pkg::DOP_KWR_N;
        state_next = rc4_pkg::ST_KWR_J;
      end
      rc4_pkg::ST_KWR_J: begin
        cmd.op = rc4_pkg::DOP_KWR_J;
        if (status.n_last) begin
          cmd.finish_ks   = 1'b1;
          need_rekey_next = 1'b0;
          state_next      = rc4_pkg::ST_PRE;
        end else begin
          state_next = rc4_pkg::ST_KRD_J;
        end
      end
      rc4_pkg::ST_PRE: begin
        cmd.start_byte = 1'b1;
        state_next     = rc4_pkg::ST_RD_J;
      end
      rc4_pkg::ST_RD_J: begin
        cmd.op     = rc4_pkg::DOP_RD_J;
        state_next = rc4_pkg::ST_RD_T;
      end
      rc4_pkg::ST_RD_T: begin
        cmd.op     = rc4_pkg::DOP_RD_T;
        state_next = rc4_pkg::ST_WR_J;
      end
      rc4_pkg::ST_WR_J: begin
        cmd.op = rc4_pkg::DOP_WR_J;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.item_last) begin
            need_rekey_next = 1'b1;
            state_next      = rc4_pkg::ST_IDLE;
          end else if (accept) begin
            cmd.take_item  = 1'b1;
            cmd.start_byte = 1'b1;
            state_next     = rc4_pkg::ST_RD_J;
          end else begin
            state_next = rc4_pkg::ST_IDLE;
          end
        end else begin
          state_next = rc4_pkg::ST_HOLD;
        end
      end
      rc4_pkg::ST_HOLD: begin
        cmd.op = rc4_pkg::DOP_HOLD;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.item_last) begin
            need_rekey_next = 1'b1;
          end
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks on sequencing.
  `RC4_ASSERT_RST(a_reset_rekeys, rst |=> (state == rc4_pkg::ST_IDLE) && need_rekey, "reset did not arm the key schedule")
  `RC4_ASSERT(a_load_needs_room, cmd.load_out |-> status.out_free, "result loaded over a held result")
  `RC4_ASSERT(a_rekey_first, (accept && need_rekey) |=> (state == rc4_pkg::ST_FILL), "byte taken without key schedule")
  `RC4_ASSERT(a_schedule_done, cmd.finish_ks |=> !need_rekey && (state == rc4_pkg::ST_PRE), "key schedule end mishandled")

endmodule

// ----- rtl/core/rc4_dp.sv -----
`timescale 1ns / 1ps
// Datapath: permutation RAM, indices, key byte select, forwarding and output register.
// Depends on rc4_pkg and instantiates rc4_ram.
module rc4_dp (
  input  logic                clk,
  input  logic                rst,
  input  rc4_pkg::cfg_t       cfg,
  input  rc4_pkg::cmd_t       cmd,
  output rc4_pkg::status_t    status,
  input  rc4_pkg::in_beat_t   in_payload,
  output logic                out_valid,
  input  logic                out_stall,
  output rc4_pkg::out_beat_t  out_payload
);

  localparam int IW = rc4_pkg::IDX_W;

  logic [IW-1:0]                   i;
  logic [IW-1:0]                   j;
  logic [IW-1:0]                   n;
  logic [rc4_pkg::KEY_IDX_W-1:0]   k;
  logic [rc4_pkg::KEY_IDX_W-1:0]   k_next;
  logic [rc4_pkg::KLEN_W-1:0]      k_inc;
  logic [rc4_pkg::KLEN_W-1:0]      len_eff;
  logic [7:0]                      key_byte;
  logic [7:0]                      si;
  logic [IW-1:0]                   t_q;
  logic [7:0]                      ks;
  logic [7:0]                      ks_q;
  rc4_pkg::in_beat_t               item;
  logic                            fwd_hit;
  logic [7:0]                      fwd_data;
  logic                            we;
  logic [IW-1:0]                   waddr;
  logic [7:0]                      wdata;
  logic [IW-1:0]                   raddr;
  logic [7:0]                      ram_rdata;
  logic [7:0]                      rd_eff;
  logic [IW-1:0]                   sum_kj;
  logic [IW-1:0]                   sum_j;
  logic [IW-1:0]                   t_sum;

  rc4_ram #(
    .WIDTH(8),
    .DEPTH(rc4_pkg::TABLE_SIZE)
  ) u_perm (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // Read data, with a write to the same address in the read cycle forwarded.
  assign rd_eff = fwd_hit ? fwd_data : ram_rdata;

  // Effective key length: zero counts as one, oversize saturates.
  always_comb begin
    if (cfg.key_length == '0) begin
      len_eff = rc4_pkg::KLEN_W'(1);
    end else if (cfg.key_length > rc4_pkg::KLEN_W'(rc4_pkg::MAX_KEY_BYTES)) begin
      len_eff = rc4_pkg::KLEN_W'(rc4_pkg::MAX_KEY_BYTES);
    end else begin
      len_eff = cfg.key_length;
    end
  end

  // Cyclic key byte index.
  assign key_byte = cfg.key[{k, 3'b000} +: 8];
  assign k_inc    = {1'b0, k} + rc4_pkg::KLEN_W'(1);
  assign k_next   = (k_inc >= len_eff) ? '0 : k_inc[rc4_pkg::KEY_IDX_W-1:0];

  // Index arithmetic, all modulo the table size.
  assign sum_kj = j + rd_eff + key_byte;
  assign sum_j  = j + rd_eff;
  assign t_sum  = si + rd_eff;

  // Keystream byte: the entry at j is still pending its write of si.
  assign ks = (t_q == j) ? si : rd_eff;

  // RAM port steering.
  always_comb begin
    we    = 1'b0;
    waddr = j;
    wdata = si;
    raddr = i + IW'(1);
    case (cmd.op)
      rc4_pkg::DOP_FILL: begin
        we    = 1'b1;
        waddr = n;
        wdata = n;
      end
      rc4_pkg::DOP_KRD_N: raddr = n;
      rc4_pkg::DOP_KRD_J: raddr = sum_kj;
      rc4_pkg::DOP_KWR_N: begin
        we    = 1'b1;
        waddr = n;
        wdata = rd_eff;
      end
      rc4_pkg::DOP_KWR_J: begin
        we    = 1'b1;
        raddr = n + IW'(1);
      end
      rc4_pkg::DOP_RD_J: raddr = sum_j;
      rc4_pkg::DOP_RD_T: begin
        we    = 1'b1;
        waddr = i;
        wdata = rd_eff;
        raddr = t_sum;
      end
      rc4_pkg::DOP_WR_J: we = 1'b1;
      default: ;
    endcase
    if (cmd.start_byte) begin
      raddr = i + IW'(1);
    end
  end

  // Indices, counters and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= '0;
      j         <= '0;
      n         <= '0;
      k         <= '0;
      fwd_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fwd_hit <= we && (raddr == waddr);
      if (cmd.start_byte) begin
        i <= i + IW'(1);
      end
      case (cmd.op)
        // The key schedule starts its mixing from j and k at zero.
        rc4_pkg::DOP_FILL: begin
          n <= n + IW'(1);
          j <= '0;
          k <= '0;
        end
        rc4_pkg::DOP_KRD_J: j <= sum_kj;
        rc4_pkg::DOP_KWR_J: begin
          n <= n + IW'(1);
          k <= k_next;
        end
        rc4_pkg::DOP_RD_J: j <= sum_j;
        default: ;
      endcase
      if (cmd.finish_ks) begin
        i <= '0;
        j <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fwd_data <= wdata;
    if (cmd.take_item) begin
      item <= in_payload;
    end
    if ((cmd.op == rc4_pkg::DOP_KRD_J) || (cmd.op == rc4_pkg::DOP_RD_J)) begin
      si <= rd_eff;
    end
    if (cmd.op == rc4_pkg::DOP_RD_T) begin
      t_q <= t_sum;
    end
    if (cmd.op == rc4_pkg::DOP_WR_J) begin
      ks_q <= ks;
    end
    if (cmd.load_out) begin
      out_payload.data_out <= item.data_in ^ ((cmd.op == rc4_pkg::DOP_HOLD) ? ks_q : ks);
      out_payload.last_out <= item.last_in;
    end
  end

  assign status.n_last    = (n == IW'(rc4_pkg::TABLE_SIZE - 1));
  assign status.out_free  = !out_valid || !out_stall;
  assign status.item_last = item.last_in;

endmodule

// ----- rtl/core/rc4_stream_cipher_top.sv -----
`timescale 1ns / 1ps
// RC4 stream cipher top level: configuration registers, sequencer and datapath.
// Depends on rc4_pkg, rc4_regs, rc4_ctrl and rc4_dp.
//
// Usage:
//   Input beats (in_valid/in_stall, in_payload) carry one byte and a last flag;
//   output beats (out_valid/out_stall, out_payload) carry the XORed byte and the
//   copied flag, one output beat per input beat, in order.
//   The key and key length are written through the APB-style port while the
//   block is idle; registers lie at byte address 8*index, pready is always high.
//   The first byte after reset, and the first after a beat marked last, starts
//   the key schedule with the current registers: it loads the identity
//   permutation, makes one priming read, runs 256 mixing steps (states KRD_J,
//   KWR_N, KWR_J) and passes a hand-off state before that byte is processed.
//   A byte passes states RD_J, RD_T and WR_J before its result is loaded into
//   the output register; the next byte of a message is taken in WR_J when the
//   output is free. The single read and single write port of the permutation
//   RAM set the pace; each byte uses them for three dependent reads and two writes.
//   Reset (rst, synchronous) clears the indices and arms the key schedule.
//   When the receiver stalls, the result waits in the output register; the next
//   byte is still taken and worked on, and waits before its own result is loaded.
module rc4_stream_cipher_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rc4_pkg::in_beat_t               in_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rc4_pkg::out_beat_t              out_payload,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rc4_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  rc4_pkg::cfg_t    cfg;
  rc4_pkg::cmd_t    cmd;
  rc4_pkg::status_t status;

  rc4_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  rc4_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  rc4_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

endmodule
